/* rtl/assert_macros.svh */
// Assertion macros shared by the route table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define RMT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Checked on every clock edge, reset included.
`define RMT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

/* rtl/rmt_pkg.sv */
// Types, codes and sizes shared by the route table decision block.
package rmt_pkg;

  localparam int MAX_ROUTES = 16;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int COUNT_W    = $clog2(MAX_ROUTES + 1);
  // Wide enough for an 8-bit entry index and for any count up to 256.
  localparam int CMP_W      = 9;
  localparam int NEXT_IDX   = (MAX_ROUTES > 1) ? 1 : 0;

  localparam logic [2:0] MODE_ROUTE  = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_UPDATE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  localparam logic [1:0] DEC_DROP    = 2'd0;
  localparam logic [1:0] DEC_FWD     = 2'd1;
  localparam logic [1:0] DEC_LOCAL   = 2'd2;
  localparam logic [1:0] DEC_BLOCK   = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  typedef struct packed {
    logic [15:0] dest;
    logic [15:0] mask;
    logic [7:0]  hop_limit;
    logic        enabled;
  } entry_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic        dest_is_group;
    logic [7:0]  hop_count;
    logic [7:0]  entry_index;
    logic [15:0] entry_dest;
    logic [15:0] entry_mask;
    logic [7:0]  entry_hop_limit;
    logic        entry_enabled;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  decision;
    logic [1:0]  status;
    logic [3:0]  index_result;
    logic [15:0] read_dest;
    logic [15:0] read_mask;
    logic [7:0]  read_hop_limit;
    logic        read_enabled;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // What the tail cell of the ring takes while the ring turns.
  typedef enum logic [1:0] {
    FEED_HEAD,
    FEED_NEW,
    FEED_NEXT
  } feed_t;

  typedef struct packed {
    logic   shift_en;
    feed_t  feed_sel;
    entry_t new_entry;
    logic [15:0] key;
  } ring_ctrl_t;

endpackage

/* rtl/rmt_cell.sv */
// One route entry of the ring, with its masked match against the lookup key.
module rmt_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  rmt_pkg::entry_t d_i,
  input  logic [15:0]     key_i,
  output rmt_pkg::entry_t q_o,
  output logic            hit_o
);
  import rmt_pkg::*;

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d_i;
    end
  end

  assign q_o   = entry_r;
  assign hit_o = entry_r.enabled && ((key_i & entry_r.mask) == (entry_r.dest & entry_r.mask));

endmodule

/* rtl/rmt_chain.sv */
// Ring of route entry cells; the head entry is presented and fed back to the tail.
module rmt_chain (
  input  logic                clk,
  input  rmt_pkg::ring_ctrl_t ctrl_i,
  output rmt_pkg::entry_t     head_o,
  output logic                head_hit_o
);
  import rmt_pkg::*;

  entry_t q   [MAX_ROUTES];
  entry_t feed;

  // Taking the head's neighbor instead of the head closes the gap of a removal.
  always_comb begin
    case (ctrl_i.feed_sel)
      FEED_HEAD: feed = q[0];
      FEED_NEW:  feed = ctrl_i.new_entry;
      FEED_NEXT: feed = q[NEXT_IDX];
      default:   feed = q[0];
    endcase
  end

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    entry_t d;
    if (i == MAX_ROUTES - 1) begin : g_tail
      assign d = feed;
    end else begin : g_body
      assign d = q[i + 1];
    end
    if (i == 0) begin : g_head
      rmt_cell u_cell (
        .clk      (clk),
        .shift_en (ctrl_i.shift_en),
        .d_i      (d),
        .key_i    (ctrl_i.key),
        .q_o      (q[i]),
        .hit_o    (head_hit_o)
      );
    end else begin : g_rest
      rmt_cell u_cell (
        .clk      (clk),
        .shift_en (ctrl_i.shift_en),
        .d_i      (d),
        .key_i    (ctrl_i.key),
        .q_o      (q[i]),
        .hit_o    ()
      );
    end
  end

  assign head_o = q[0];

endmodule

/* rtl/masked_route_table_decision.sv */
// Top level: routing decision and route table maintenance over a ring of entry cells.
//
//  Channel | Ports                              | Moves
//  --------+------------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data        | one request (route or table op)
//  output  | out_valid, out_ready, out_data     | one result per request
//  config  | cfg_valid, cfg_ready, cfg_data     | own individual address
//
// Every request turns the ring once, one entry passing the head cell per cycle. The
// request is taken before the turn, and the result register is loaded after it;
// no new request is taken until then.
// Reset clears the control state and the entry count; entries are undefined.
// A new request is taken while the previous result still waits for its transfer;
// a request that finishes its turn holds until the result register is free.
`include "assert_macros.svh"

module masked_route_table_decision (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rmt_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import rmt_pkg::*;

  state_t             state_r, state_nxt;
  in_item_t           req_r;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] used_r, used_nxt;
  logic [15:0]        own_r;
  logic               found_r;
  logic               found_drop_r;
  entry_t             rd_entry_r;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  ring_ctrl_t         ring_ctrl;
  entry_t             head;
  logic               head_hit;

  logic [CMP_W-1:0]   k_cmp, used_cmp, idx_cmp;
  logic               idx_ok, full, in_take, out_load;
  logic [1:0]         route_dec;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign k_cmp    = CMP_W'(cnt_r);
  assign used_cmp = CMP_W'(used_r);
  assign idx_cmp  = CMP_W'(req_r.entry_index);
  assign idx_ok   = idx_cmp < used_cmp;
  assign full     = used_cmp == CMP_W'(MAX_ROUTES);

  always_comb begin
    ring_ctrl.shift_en            = (state_r == ST_SCAN);
    ring_ctrl.key                 = req_r.dest_address;
    ring_ctrl.new_entry.dest      = req_r.entry_dest;
    ring_ctrl.new_entry.mask      = req_r.entry_mask;
    ring_ctrl.new_entry.hop_limit = req_r.entry_hop_limit;
    ring_ctrl.new_entry.enabled   = req_r.entry_enabled;
    ring_ctrl.feed_sel            = FEED_HEAD;
    case (req_r.mode)
      MODE_APPEND: begin
        if (!full && k_cmp == used_cmp) begin
          ring_ctrl.feed_sel = FEED_NEW;
        end
      end
      MODE_UPDATE: begin
        if (idx_ok && k_cmp == idx_cmp) begin
          ring_ctrl.feed_sel = FEED_NEW;
        end
      end
      MODE_REMOVE: begin
        if (idx_ok && k_cmp >= idx_cmp) begin
          ring_ctrl.feed_sel = FEED_NEXT;
        end
      end
      default: ring_ctrl.feed_sel = FEED_HEAD;
    endcase
  end

  rmt_chain u_chain (
    .clk        (clk),
    .ctrl_i     (ring_ctrl),
    .head_o     (head),
    .head_hit_o (head_hit)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(MAX_ROUTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Fixed checks come first; the table scan only decides what they leave open.
  always_comb begin
    if (req_r.hop_count == 8'd0) begin
      route_dec = DEC_DROP;
    end else if (req_r.dest_is_group) begin
      route_dec = DEC_FWD;
    end else if (req_r.dest_address == own_r || req_r.dest_address == req_r.source_address) begin
      route_dec = DEC_DROP;
    end else if (req_r.dest_address[15:8] == own_r[15:8]) begin
      route_dec = DEC_LOCAL;
    end else if (req_r.dest_address[15:12] == own_r[15:12]) begin
      route_dec = DEC_FWD;
    end else if (found_r) begin
      route_dec = found_drop_r ? DEC_DROP : DEC_FWD;
    end else begin
      route_dec = DEC_BLOCK;
    end
  end

  always_comb begin
    out_nxt  = '0;
    used_nxt = used_r;
    case (req_r.mode)
      MODE_ROUTE: out_nxt.decision = route_dec;
      MODE_APPEND: begin
        if (full) begin
          out_nxt.status = STAT_FULL;
        end else begin
          out_nxt.index_result = 4'(used_r);
          used_nxt             = used_r + COUNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (idx_ok) begin
          used_nxt = used_r - COUNT_W'(1);
        end else begin
          out_nxt.status = STAT_RANGE;
        end
      end
      MODE_UPDATE: begin
        if (!idx_ok) begin
          out_nxt.status = STAT_RANGE;
        end
      end
      MODE_CLEAR: used_nxt = '0;
      MODE_READ: begin
        if (idx_ok) begin
          out_nxt.read_dest      = rd_entry_r.dest;
          out_nxt.read_mask      = rd_entry_r.mask;
          out_nxt.read_hop_limit = rd_entry_r.hop_limit;
          out_nxt.read_enabled   = rd_entry_r.enabled;
        end else begin
          out_nxt.status = STAT_RANGE;
        end
      end
      default: out_nxt = '0;
    endcase
    out_nxt.entry_count = 5'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      used_r      <= '0;
      own_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        own_r <= cfg_data;
      end
      if (in_take) begin
        found_r <= 1'b0;
      end else if (state_r == ST_SCAN && req_r.mode == MODE_ROUTE && k_cmp < used_cmp
                   && !found_r && head_hit) begin
        found_r <= 1'b1;
      end
      if (out_load) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
    if (state_r == ST_SCAN && !found_r && head_hit) begin
      found_drop_r <= req_r.hop_count > head.hop_limit;
    end
    if (state_r == ST_SCAN && k_cmp == idx_cmp) begin
      rd_entry_r <= head;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  `RMT_ASSERT(a_used_bound, used_cmp <= CMP_W'(MAX_ROUTES))
  `RMT_ASSERT(a_take_starts_scan, in_valid && in_ready |=> state_r == ST_SCAN)
  `RMT_ASSERT(a_count_only_on_done, state_r != ST_DONE |=> $stable(used_r))
  `RMT_ASSERT(a_cnt_idle, state_r != ST_SCAN |-> cnt_r == '0)

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the masked route table decision block.
module tb_top;
  import rmt_pkg::*;

  // Request modes that the block treats as no-ops.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  class route_table_tracker;
    logic [15:0] own_addr;
    entry_t      entries[MAX_ROUTES];
    int          used;
    out_item_t   pending_results[$];
    int          errors;
    int          checked;
    int          decisions[4];
    int          full_replies;
    int          range_replies;

    function new();
      own_addr = '0;
      used = 0;
      errors = 0;
      checked = 0;
      full_replies = 0;
      range_replies = 0;
      foreach (decisions[i]) decisions[i] = 0;
    endfunction

    function logic [1:0] decide_route(in_item_t req);
      if (req.hop_count == 8'd0) return DEC_DROP;
      if (req.dest_is_group) return DEC_FWD;
      if (req.dest_address == own_addr || req.dest_address == req.source_address)
        return DEC_DROP;
      if (req.dest_address[15:8] == own_addr[15:8]) return DEC_LOCAL;
      if (req.dest_address[15:12] == own_addr[15:12]) return DEC_FWD;
      // The first enabled entry that matches under its mask decides.
      for (int i = 0; i < used; i++) begin
        if (entries[i].enabled &&
            ((req.dest_address & entries[i].mask) == (entries[i].dest & entries[i].mask)))
          return (req.hop_count > entries[i].hop_limit) ? DEC_DROP : DEC_FWD;
      end
      return DEC_BLOCK;
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      entry_t    fresh;
      res = '0;
      fresh.dest = req.entry_dest;
      fresh.mask = req.entry_mask;
      fresh.hop_limit = req.entry_hop_limit;
      fresh.enabled = req.entry_enabled;
      case (req.mode)
        MODE_ROUTE: begin
          res.decision = decide_route(req);
          decisions[res.decision]++;
        end
        MODE_APPEND: begin
          if (used >= MAX_ROUTES) begin
            res.status = STAT_FULL;
          end else begin
            entries[used] = fresh;
            res.index_result = 4'(used);
            used++;
          end
        end
        MODE_REMOVE: begin
          if (req.entry_index >= used) begin
            res.status = STAT_RANGE;
          end else begin
            for (int i = req.entry_index; i + 1 < used; i++) entries[i] = entries[i + 1];
            used--;
          end
        end
        MODE_UPDATE: begin
          if (req.entry_index >= used) res.status = STAT_RANGE;
          else entries[req.entry_index] = fresh;
        end
        MODE_CLEAR: begin
          used = 0;
        end
        MODE_READ: begin
          if (req.entry_index >= used) begin
            res.status = STAT_RANGE;
          end else begin
            res.read_dest = entries[req.entry_index].dest;
            res.read_mask = entries[req.entry_index].mask;
            res.read_hop_limit = entries[req.entry_index].hop_limit;
            res.read_enabled = entries[req.entry_index].enabled;
          end
        end
        default: begin
        end
      endcase
      if (res.status == STAT_FULL) full_replies++;
      if (res.status == STAT_RANGE) range_replies++;
      res.entry_count = 5'(used);
      pending_results = {pending_results, res};
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("decision", 16'(want.decision), 16'(got.decision));
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("index_result", 16'(want.index_result), 16'(got.index_result));
      compare_field("read_dest", want.read_dest, got.read_dest);
      compare_field("read_mask", want.read_mask, got.read_mask);
      compare_field("read_hop_limit", 16'(want.read_hop_limit), 16'(got.read_hop_limit));
      compare_field("read_enabled", 16'(want.read_enabled), 16'(got.read_enabled));
      compare_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  route_table_tracker board = new();
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int sent = 0;

  masked_route_table_decision i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check every transfer, then decide whether to stall next cycle.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_result(out_data);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 160;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t random_noise();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t frame(logic [15:0] src, logic [15:0] dst, logic grp,
                                     logic [7:0] hops);
    in_item_t r;
    r = random_noise();
    r.mode = MODE_ROUTE;
    r.source_address = src;
    r.dest_address = dst;
    r.dest_is_group = grp;
    r.hop_count = hops;
    return r;
  endfunction

  function automatic in_item_t table_op(logic [2:0] op, logic [7:0] idx, logic [15:0] dst,
                                        logic [15:0] msk, logic [7:0] lim, logic en);
    in_item_t r;
    r = random_noise();
    r.mode = op;
    r.entry_index = idx;
    r.entry_dest = dst;
    r.entry_mask = msk;
    r.entry_hop_limit = lim;
    r.entry_enabled = en;
    return r;
  endfunction

  // Mostly valid positions, sometimes exactly one past the end or anything at all.
  function automatic logic [7:0] pick_index(logic [7:0] noise);
    if (board.used > 0 && $urandom_range(0, 3) != 0) return 8'($urandom_range(0, board.used - 1));
    if ($urandom_range(0, 1) == 0) return 8'(board.used);
    return noise;
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    entry_t   pick;
    int       roll;
    r = random_noise();
    roll = $urandom_range(0, 99);
    if (roll < 42 && board.used > 0) begin
      // Aim at a stored entry so that lookups hit, with random don't-care bits.
      r.mode = MODE_ROUTE;
      pick = board.entries[$urandom_range(0, board.used - 1)];
      r.dest_address = (pick.dest & pick.mask) | (r.dest_address & ~pick.mask);
      r.dest_is_group = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 3))
        0: r.hop_count = pick.hop_limit;
        1: r.hop_count = pick.hop_limit + 8'd1;
        2: r.hop_count = 8'($urandom_range(1, 255));
        default: r.hop_count = 8'hFF;
      endcase
    end else if (roll < 52) begin
      r.mode = MODE_ROUTE;
      if ($urandom_range(0, 7) == 0) r.hop_count = 8'd0;
      if ($urandom_range(0, 7) == 0) r.source_address = r.dest_address;
      if ($urandom_range(0, 3) == 0) r.dest_address = board.own_addr ^ 16'($urandom_range(0, 4095));
    end else if (roll < 74) begin
      r.mode = MODE_APPEND;
      case ($urandom_range(0, 4))
        0: r.entry_mask = 16'hFFFF;
        1: r.entry_mask = 16'hFF00;
        2: r.entry_mask = 16'hF000;
        3: r.entry_mask = 16'h0000;
        default: ;
      endcase
      r.entry_enabled = ($urandom_range(0, 4) != 0);
    end else if (roll < 82) begin
      r.mode = MODE_REMOVE;
      r.entry_index = pick_index(r.entry_index);
    end else if (roll < 88) begin
      r.mode = MODE_UPDATE;
      r.entry_index = pick_index(r.entry_index);
    end else if (roll < 96) begin
      r.mode = MODE_READ;
      r.entry_index = pick_index(r.entry_index);
    end else if (roll < 98) begin
      r.mode = MODE_CLEAR;
    end else begin
      r.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
    end
    return r;
  endfunction

  task automatic send_request(in_item_t req);
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(req);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic set_own_address(logic [15:0] addr);
    cfg_data <= addr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.own_addr = addr;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Every request produces a result, so an empty queue means the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic run_random(int count, int tail);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count - tail);
      send_request(random_request());
    end
  endtask

  task automatic run_directed();
    send_request(frame(16'h5501, 16'h3401, 1'b0, 8'h00));   // zero hops drop
    send_request(frame(16'h5501, 16'h1203, 1'b1, 8'h06));   // group wins over own
    send_request(frame(16'h5501, 16'h1203, 1'b0, 8'h06));   // own address
    send_request(frame(16'h7711, 16'h7711, 1'b0, 8'h06));   // source address
    send_request(frame(16'h0000, 16'h12FF, 1'b0, 8'hFF));   // same line
    send_request(frame(16'hFFFF, 16'h1EFF, 1'b0, 8'h01));   // same area
    send_request(frame(16'h5501, 16'h3401, 1'b0, 8'h06));   // empty table blocks
    send_request(table_op(MODE_READ, 8'd0, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(table_op(MODE_REMOVE, 8'd0, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(table_op(MODE_UPDATE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    send_request(table_op(MODE_APPEND, 8'd0, 16'h3400, 16'hFF00, 8'd5, 1'b0));
    send_request(table_op(MODE_APPEND, 8'd0, 16'h3400, 16'hFF00, 8'd5, 1'b1));
    send_request(table_op(MODE_APPEND, 8'd0, 16'h0000, 16'h0000, 8'hFF, 1'b1));
    send_request(frame(16'h5501, 16'h3401, 1'b0, 8'd5));    // disabled entry skipped
    send_request(frame(16'h5501, 16'h3401, 1'b0, 8'd6));    // over the hop limit
    send_request(frame(16'h0000, 16'hFFFF, 1'b0, 8'hFF));   // catch-all entry
    send_request(table_op(MODE_UPDATE, 8'd2, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1));
    send_request(table_op(MODE_READ, 8'd2, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(frame(16'h0000, 16'hFFFF, 1'b0, 8'h01));
    send_request(table_op(MODE_REMOVE, 8'd1, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(table_op(MODE_READ, 8'd1, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(table_op(MODE_SPARE_A, 8'd0, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(table_op(MODE_SPARE_B, 8'd0, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(table_op(MODE_CLEAR, 8'd0, 16'h0, 16'h0, 8'h0, 1'b0));
    send_request(frame(16'h5501, 16'h3401, 1'b0, 8'd1));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_own_address(16'h1203);
    run_directed();
    drain();

    // The receiver holds off at the start of this phase so the input backs up.
    set_own_address(16'hFFFF);
    long_hold_req = 1'b1;
    run_random(250, 0);
    drain();

    set_own_address(16'h0000);
    run_random(250, 0);
    drain();

    set_own_address(16'($urandom));
    run_random(330, 120);
    drain();

    $display("Sent %0d requests under four own addresses, checked %0d results.",
             sent, board.checked);
    $display("Routes: %0d drop, %0d forward, %0d local, %0d block; %0d full, %0d bad index.",
             board.decisions[DEC_DROP], board.decisions[DEC_FWD],
             board.decisions[DEC_LOCAL], board.decisions[DEC_BLOCK],
             board.full_replies, board.range_replies);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
